>>> hdl/evt_pkg.sv
// ----------------------------------------------------------------------------
// Element vector table package
// Request and response payload types, request kinds, status codes and the
// token that walks the row of storage cells.
// ----------------------------------------------------------------------------
package evt_pkg;

    // Request kinds carried in req_type.
    localparam logic [2:0] REQ_PUSH      = 3'd0;
    localparam logic [2:0] REQ_POP       = 3'd1;
    localparam logic [2:0] REQ_READ      = 3'd2;
    localparam logic [2:0] REQ_WRITE     = 3'd3;
    localparam logic [2:0] REQ_DELETE    = 3'd4;
    localparam logic [2:0] REQ_READ_LAST = 3'd5;

    // Status codes of a response.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [5:0]  index;
        logic [31:0] value;
    } t_evt_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] read_data;
        logic [5:0]  slot_index;
        logic [6:0]  count;
    } t_evt_rsp;

    // Control part of the token handed from one cell to the next.
    typedef struct packed {
        logic vld;
        logic found;
    } t_evt_tok;

endpackage

>>> hdl/evt_cell.sv
// ----------------------------------------------------------------------------
// Element vector table storage cell
// Holds one element. When the request token passes, the cell writes,
// reads, or takes over its upper neighbor's element during a delete.
// ----------------------------------------------------------------------------
module evt_cell #(
    parameter int POS = 0,
    parameter int CW  = 7,
    parameter int EW  = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [2:0]       i_op,
    input  logic             i_act,
    input  logic [CW-1:0]    i_tgt,
    input  logic [CW-1:0]    i_count,
    input  logic [EW-1:0]    i_val,
    input  evt_pkg::t_evt_tok i_tok,
    input  logic [EW-1:0]    i_rdata,
    input  logic [EW-1:0]    i_next_elem,
    output evt_pkg::t_evt_tok o_tok,
    output logic [EW-1:0]    o_rdata,
    output logic [EW-1:0]    o_elem
);
    import evt_pkg::*;

    localparam logic [CW-1:0] POS_C = CW'(POS);

    logic [EW-1:0] r_elem;
    logic [EW-1:0] r_rdata;
    logic          r_tok_vld;
    logic          r_found;
    logic          w_tgt_hit;
    logic          w_live;
    logic          w_match;
    logic          w_hit;
    logic          w_go;

    assign w_go      = i_tok.vld && i_act;
    assign w_tgt_hit = (POS_C == i_tgt);
    assign w_live    = (POS_C < i_count);
    assign w_match   = w_live && (r_elem == i_val);
    // Once a lower cell has matched, every cell above shifts down by one.
    assign w_hit     = i_tok.found || w_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_vld <= 1'b0;
        end else begin
            r_tok_vld <= i_tok.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            if ((i_op == REQ_PUSH || i_op == REQ_WRITE) && w_tgt_hit) begin
                r_elem <= i_val;
            end else if (i_op == REQ_DELETE && w_hit) begin
                r_elem <= i_next_elem;
            end
        end
        if (w_go && (i_op == REQ_READ || i_op == REQ_READ_LAST) && w_tgt_hit) begin
            r_rdata <= r_elem;
        end else begin
            r_rdata <= i_rdata;
        end
        r_found <= (i_op == REQ_DELETE) && w_hit;
    end

    assign o_tok   = '{vld: r_tok_vld, found: r_found};
    assign o_rdata = r_rdata;
    assign o_elem  = r_elem;

endmodule

>>> hdl/element_vector_table.sv
// ----------------------------------------------------------------------------
// Element vector table
// Bounded table with push, pop, indexed read and write, read of the last
// element, and delete of the first matching element.
// ----------------------------------------------------------------------------
// The table is a row of DEPTH cells. Each request becomes a token that walks
// the row one cell per cycle, and one request is in the table at a time. A
// new request is taken as soon as the previous result has been loaded into
// the output register, even while that result still waits for its transfer.
// There is no clearing pass after reset: only entries below the count are
// ever read.
module element_vector_table #(
    parameter int DEPTH      = 64,
    parameter int ELEM_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  evt_pkg::t_evt_req i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output evt_pkg::t_evt_rsp o_out
);
    import evt_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (CW > 6) ? CW : 6;
    localparam int EW = ELEM_WIDTH;

    logic              r_busy;
    logic              r_start;
    logic [2:0]        r_op;
    logic              r_act;
    logic [1:0]        r_st;
    logic [CW-1:0]     r_tgt;
    logic [EW-1:0]     r_val;
    logic [CW-1:0]     r_count;
    logic              r_pend_vld;
    logic              r_pend_found;
    logic [EW-1:0]     r_pend_rdata;
    logic              r_out_valid;
    t_evt_rsp          r_out;

    logic              w_acc;
    logic              w_load;
    logic              n_act;
    logic [1:0]        n_st;
    logic [CW-1:0]     n_tgt;
    logic [CW-1:0]     n_count;
    logic [IW-1:0]     w_idx_x;
    logic [IW-1:0]     w_cnt_x;
    logic [63:0]       w_val64;
    logic [63:0]       w_rd64;
    t_evt_rsp          n_out;

    t_evt_tok          w_tok  [DEPTH+1];
    logic [EW-1:0]     w_rd   [DEPTH+1];
    logic [EW-1:0]     w_elem [DEPTH+1];

    assign o_in_ready  = !r_busy;
    assign w_acc       = i_in_valid && !r_busy;
    assign w_load      = r_pend_vld && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign w_idx_x = IW'(i_in.index);
    assign w_cnt_x = IW'(r_count);
    assign w_val64 = 64'(i_in.value);
    assign w_rd64  = 64'(r_pend_rdata);

    // Everything but delete is decided from the count at the transfer.
    always_comb begin
        n_act = 1'b0;
        n_st  = ST_OK;
        n_tgt = '0;
        unique case (i_in.req_type) inside
            REQ_PUSH: begin
                if (r_count == CW'(DEPTH)) begin
                    n_st = ST_FULL;
                end else begin
                    n_act = 1'b1;
                    n_tgt = r_count;
                end
            end
            REQ_POP: begin
                if (r_count == '0) begin
                    n_st = ST_EMPTY;
                end else begin
                    n_act = 1'b1;
                end
            end
            REQ_READ, REQ_WRITE: begin
                if (w_idx_x >= w_cnt_x) begin
                    n_st = ST_RANGE;
                end else begin
                    n_act = 1'b1;
                    n_tgt = CW'(i_in.index);
                end
            end
            REQ_DELETE: begin
                n_act = 1'b1;
            end
            REQ_READ_LAST: begin
                if (r_count == '0) begin
                    n_st = ST_EMPTY;
                end else begin
                    n_act = 1'b1;
                    n_tgt = r_count - CW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (r_act && r_op == REQ_PUSH) begin
            n_count = r_count + CW'(1);
        end else if (r_act && r_op == REQ_POP) begin
            n_count = r_count - CW'(1);
        end else if (r_op == REQ_DELETE && r_pend_found) begin
            n_count = r_count - CW'(1);
        end
        n_out.status     = (r_op == REQ_DELETE) ? (r_pend_found ? ST_OK : ST_EMPTY) : r_st;
        n_out.read_data  = w_rd64[31:0];
        n_out.slot_index = (r_act && r_op == REQ_PUSH) ? 6'(r_tgt) : 6'd0;
        n_out.count      = 7'(n_count);
    end

    assign w_tok[0]      = '{vld: r_start, found: 1'b0};
    assign w_rd[0]       = '0;
    assign w_elem[DEPTH] = '0;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        evt_cell #(
            .POS (k),
            .CW  (CW),
            .EW  (EW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_op        (r_op),
            .i_act       (r_act),
            .i_tgt       (r_tgt),
            .i_count     (r_count),
            .i_val       (r_val),
            .i_tok       (w_tok[k]),
            .i_rdata     (w_rd[k]),
            .i_next_elem (w_elem[k+1]),
            .o_tok       (w_tok[k+1]),
            .o_rdata     (w_rd[k+1]),
            .o_elem      (w_elem[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_start     <= 1'b0;
            r_count     <= '0;
            r_pend_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= w_acc;
            if (w_acc) begin
                r_busy <= 1'b1;
                r_op   <= i_in.req_type;
                r_act  <= n_act;
                r_st   <= n_st;
                r_tgt  <= n_tgt;
                r_val  <= w_val64[EW-1:0];
            end
            // The token leaving the top cell closes the walk.
            if (w_tok[DEPTH].vld) begin
                r_pend_vld   <= 1'b1;
                r_pend_found <= w_tok[DEPTH].found;
                r_pend_rdata <= w_rd[DEPTH];
            end
            if (w_load) begin
                r_pend_vld  <= 1'b0;
                r_busy      <= 1'b0;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
                r_out       <= n_out;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

>>> hdl/evt_checker.sv
// ----------------------------------------------------------------------------
// Element vector table port checker
// Watches the top-level ports for handshake and response consistency.
// ----------------------------------------------------------------------------
module evt_checker #(
    parameter int DEPTH = 64
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input evt_pkg::t_evt_rsp o_out
);
    import evt_pkg::*;

    // A result waiting for its transfer must hold still.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed before its transfer");

    // One request at a time: after an input transfer the block is busy.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second request taken while one is in the table");

    // A full report only comes with a full table.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status == ST_FULL |-> o_out.count == 7'(DEPTH))
        else $error("full status with a table that is not full");

    // A failed request returns no data and no slot.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status != ST_OK
        |-> o_out.read_data == 32'd0 && o_out.slot_index == 6'd0)
        else $error("failed request returned data");

endmodule

bind element_vector_table evt_checker #(.DEPTH(DEPTH)) u_evt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
